// File: rtl/e1900_pkg.sv
// ----------------------------------------------------------------------------
// e1900_pkg
// Shared types, constants and the month start table for the converter that
// turns seconds since 1900 into a calendar date and time of day.
// ----------------------------------------------------------------------------
package e1900_pkg;

  // Whole days come from (seconds >> 7) / 675, since 86400 = 128 * 675.
  localparam logic [24:0] DAY_RECIP  = 25'd25451658;  // floor(2^34 / 675)
  localparam logic [9:0]  DAY_ODD    = 10'd675;
  localparam logic [8:0]  DAY_LOW    = 9'd365;         // days in a common year
  localparam logic [15:0] CYC_RECIP  = 16'd45933;      // floor(2^26 / 1461)
  localparam logic [10:0] CYC_DAYS   = 11'd1461;       // days in four years
  localparam logic [12:0] HOUR_RECIP = 13'd4661;       // ceil(2^20 / 225)
  localparam logic [11:0] SECS_HOUR  = 12'd3600;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;       // ceil(2^14 / 15)
  localparam logic [5:0]  SECS_MIN   = 6'd60;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;      // ceil(2^19 / 7)
  localparam logic [2:0]  WEEK_DAYS  = 3'd7;
  localparam logic [10:0] BASE_YEAR  = 11'd1900;

  typedef struct packed {
    logic [10:0] year;
    logic [8:0]  doy;   // day of year from 0
    logic        leap;
  } ydate_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
    logic [2:0] wday;
  } tod_t;

  // First day of year for a month index from 0.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// File: rtl/epoch1900_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch1900_seconds_to_calendar_unit
// Converts seconds since 1900-01-01 00:00 UTC to Gregorian date, time of day
// and weekday.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// s_*      in   tdata[31:0] seconds
// m_*      out  tdata[39:0] year, month, day, hour, minute, sec_of_minute, weekday
//
// One word enters per cycle while the output register is empty or taken.
// The pipeline is the day split (3 stages), year search (5) and month search (2).
// All stages advance together whenever the output register is empty or taken.
// Reset empties the pipeline; no table needs clearing.
// ----------------------------------------------------------------------------
module epoch1900_seconds_to_calendar_unit import e1900_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  // year[10:0], month[14:11], day[19:15], hour[24:20], minute[30:25],
  // sec_of_minute[36:31], weekday[39:37]
  output logic [39:0] m_tdata
);

  logic        en;
  logic        ds_valid;
  logic [15:0] days;
  logic [16:0] sod;
  logic        yr_valid;
  ydate_t      ydate;
  logic [10:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  tod_t        tod;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  e1900_daysplit u_daysplit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .seconds   (s_tdata),
    .out_valid (ds_valid),
    .days      (days),
    .sod       (sod)
  );

  e1900_year u_year (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ds_valid),
    .days      (days),
    .out_valid (yr_valid),
    .ydate     (ydate)
  );

  e1900_month u_month (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (yr_valid),
    .ydate     (ydate),
    .out_valid (m_tvalid),
    .year      (year),
    .month     (month),
    .day       (day)
  );

  e1900_tod u_tod (
    .clk  (clk),
    .en   (en),
    .days (days),
    .sod  (sod),
    .tod  (tod)
  );

  assign m_tdata = {tod.wday, tod.sec, tod.minute, tod.hour, day, month, year};

`ifndef ASSERT_OFF
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (year >= 11'd1900) && (year <= 11'd2036))
    else $error("year out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (tod.hour <= 5'd23) && (tod.minute <= 6'd59) &&
                 (tod.sec <= 6'd59) && (tod.wday <= 3'd6))
    else $error("time of day or weekday out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word present after reset");
`endif

endmodule

// File: rtl/e1900_daysplit.sv
// ----------------------------------------------------------------------------
// e1900_daysplit
// Three stage split of the second count into whole days and second of day,
// using a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module e1900_daysplit import e1900_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] seconds,
  output logic        out_valid,
  output logic [15:0] days,
  output logic [16:0] sod
);

  logic        v1, v2;
  logic [24:0] q1, q2;
  logic [6:0]  lo1, lo2;
  logic [49:0] p1;
  logic [15:0] est2;
  logic [24:0] p2;
  logic [24:0] diff;
  logic        fix;
  logic [24:0] rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // The estimate may fall one short of the true quotient; stage three fixes it.
  always_comb begin
    diff = q2 - p2;
    fix  = diff >= 25'(DAY_ODD);
    rem  = fix ? (diff - 25'(DAY_ODD)) : diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1   <= seconds[31:7];
      lo1  <= seconds[6:0];
      p1   <= 50'(seconds[31:7]) * 50'(DAY_RECIP);
      q2   <= q1;
      lo2  <= lo1;
      est2 <= p1[49:34];
      p2   <= 25'(p1[49:34]) * 25'(DAY_ODD);
      days <= est2 + 16'(fix);
      sod  <= {rem[9:0], lo2};
    end
  end

endmodule

// File: rtl/e1900_year.sv
// ----------------------------------------------------------------------------
// e1900_year
// Five stage year search. After 1900 the leap years repeat every four years
// through 2036, so the year comes from a division by 1461 days.
// ----------------------------------------------------------------------------
module e1900_year import e1900_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] days,
  output logic        out_valid,
  output ydate_t      ydate
);

  logic [3:0]  v;
  logic        first1, first2, first3, first4;
  logic [8:0]  dlo1, dlo2, dlo3, dlo4;
  logic [15:0] d1, d2, d3;
  logic [31:0] p2;
  logic [5:0]  q3, q4;
  logic [15:0] m3;
  logic [15:0] diff;
  logic        fix;
  logic [10:0] r4;
  logic [1:0]  yoff;
  logic [8:0]  doy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[2:0], in_valid};
      out_valid <= v[3];
    end
  end

  always_comb begin
    diff = d3 - m3;
    fix  = diff >= 16'(CYC_DAYS);
  end

  // Position inside the four year cycle that starts with 1901.
  always_comb begin
    if (r4 < 11'd365) begin
      yoff = 2'd0;
    end else if (r4 < 11'd730) begin
      yoff = 2'd1;
    end else if (r4 < 11'd1095) begin
      yoff = 2'd2;
    end else begin
      yoff = 2'd3;
    end
    doy = 9'(r4 - 11'(yoff) * 11'(DAY_LOW));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first1 <= days < 16'(DAY_LOW);
      d1     <= days - 16'(DAY_LOW);
      dlo1   <= days[8:0];
      first2 <= first1;
      dlo2   <= dlo1;
      d2     <= d1;
      p2     <= 32'(d1) * 32'(CYC_RECIP);
      first3 <= first2;
      dlo3   <= dlo2;
      d3     <= d2;
      q3     <= p2[31:26];
      m3     <= 16'(p2[31:26]) * 16'(CYC_DAYS);
      first4 <= first3;
      dlo4   <= dlo3;
      q4     <= q3 + 6'(fix);
      r4     <= fix ? 11'(diff - 16'(CYC_DAYS)) : 11'(diff);
      if (first4) begin
        ydate.year <= BASE_YEAR;
        ydate.doy  <= dlo4;
        ydate.leap <= 1'b0;
      end else begin
        ydate.year <= BASE_YEAR + 11'd1 + {3'd0, q4, 2'b00} + 11'(yoff);
        ydate.doy  <= doy;
        ydate.leap <= yoff == 2'd3;
      end
    end
  end

endmodule

// File: rtl/e1900_month.sv
// ----------------------------------------------------------------------------
// e1900_month
// Two stage month search: parallel compares against the month start table,
// then the day of month from the chosen start.
// ----------------------------------------------------------------------------
module e1900_month import e1900_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  ydate_t      ydate,
  output logic        out_valid,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  logic        v1;
  logic [3:0]  mi, mi1;
  logic [10:0] year1;
  logic [8:0]  doy1;
  logic        leap1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Starts rise with the month, so the last start passed is the month.
  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (ydate.doy >= month_start(4'(k), ydate.leap)) begin
        mi = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mi1   <= mi;
      year1 <= ydate.year;
      doy1  <= ydate.doy;
      leap1 <= ydate.leap;
      year  <= year1;
      month <= mi1 + 4'd1;
      day   <= 5'(doy1 - month_start(mi1, leap1) + 9'd1);
    end
  end

endmodule

// File: rtl/e1900_tod.sv
// ----------------------------------------------------------------------------
// e1900_tod
// Hour, minute, second and weekday by reciprocal multiplies, delayed to line
// up with the seven stage year and month path.
// ----------------------------------------------------------------------------
module e1900_tod import e1900_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] days,
  input  logic [16:0] sod,
  output tod_t        tod
);

  logic [25:0] hp1;
  logic [31:0] wp1;
  logic [16:0] sod1;
  logic [15:0] x1;
  logic [4:0]  hour1;
  logic [12:0] wq1;
  logic [4:0]  hour2, hour3;
  logic [11:0] mos2, mos3;
  logic [2:0]  wday2, wday3;
  logic [19:0] mp3;
  logic [5:0]  minute3;
  tod_t        dly [4];

  always_comb begin
    hour1   = hp1[24:20];
    wq1     = wp1[31:19];
    minute3 = mp3[19:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sod1   <= sod;
      x1     <= days + 16'd1;
      hp1    <= 26'(sod[16:4]) * 26'(HOUR_RECIP);
      wp1    <= 32'(days + 16'd1) * 32'(WEEK_RECIP);
      hour2  <= hour1;
      mos2   <= 12'(sod1 - 17'(hour1) * 17'(SECS_HOUR));
      wday2  <= 3'(x1 - 16'(wq1) * 16'(WEEK_DAYS));
      hour3  <= hour2;
      mos3   <= mos2;
      wday3  <= wday2;
      mp3    <= 20'(mos2[11:2]) * 20'(MIN_RECIP);
      dly[0] <= '{hour:   hour3,
                  minute: minute3,
                  sec:    6'(mos3 - 12'(minute3) * 12'(SECS_MIN)),
                  wday:   wday3};
      dly[1] <= dly[0];
      dly[2] <= dly[1];
      dly[3] <= dly[2];
    end
  end

  assign tod = dly[3];

endmodule
